// ===== rtl/ctts_pkg.sv =====
// ----------------------------------------------------------------------------
// ctts_pkg: shared types and constants for the charge-transfer touch sensor
// Holds the register map, the reset values, the filter load value and the
// per-tick result word.
// ----------------------------------------------------------------------------
`default_nettype none

package ctts_pkg;

    localparam int unsigned REG_W   = 16;
    localparam int unsigned INDEX_W = 3;

    // Register map
    localparam logic [INDEX_W-1:0] REG_CHARGE_TICKS    = 3'd0;
    localparam logic [INDEX_W-1:0] REG_TRANSFER_TICKS  = 3'd1;
    localparam logic [INDEX_W-1:0] REG_DISCHARGE_TICKS = 3'd2;
    localparam logic [INDEX_W-1:0] REG_COUNT_LIMIT     = 3'd3;
    localparam logic [INDEX_W-1:0] REG_LEVEL_OFFSET    = 3'd4;

    // Register reset values
    localparam logic [REG_W-1:0] RST_CHARGE_TICKS    = 16'd1;
    localparam logic [REG_W-1:0] RST_TRANSFER_TICKS  = 16'd1;
    localparam logic [REG_W-1:0] RST_DISCHARGE_TICKS = 16'd3000;
    localparam logic [REG_W-1:0] RST_COUNT_LIMIT     = 16'd65534;
    localparam logic [REG_W-1:0] RST_LEVEL_OFFSET    = 16'd1395;

    // First measurement seeds the filter with this value
    localparam logic [REG_W-1:0] FILTER_LOAD = 16'hFFFE;
    localparam logic [REG_W-1:0] COUNT_MAX   = 16'hFFFF;

    typedef struct packed {
        logic       sense_drive_enable;
        logic       sense_drive_high;
        logic       reference_ground_enable;
        logic       level_valid;
        logic [7:0] level_byte;
    } ctts_result_t;

endpackage

`default_nettype wire

// ===== rtl/ctts_filter.sv =====
// ----------------------------------------------------------------------------
// ctts_filter: 7/8 IIR filter update and byte scaling
// Loads the filter while it is zero (as on first use), else blends in the new count; then removes
// the offset, drops four bits and saturates to a byte.
// ----------------------------------------------------------------------------
`default_nettype none

module ctts_filter
(
    input  wire logic [ctts_pkg::REG_W-1:0] filtered_count,
    input  wire logic [ctts_pkg::REG_W-1:0] cycle_count,
    input  wire logic [ctts_pkg::REG_W-1:0] level_offset,
    output logic      [ctts_pkg::REG_W-1:0] filtered_next,
    output logic      [7:0]                 level_byte
);

    logic [18:0] blend_sum;
    logic [15:0] diff;
    logic [11:0] scaled;

    // 7*f + count as (f << 3) - f + count, 19 bits never overflow
    assign blend_sum = {filtered_count, 3'b000} - {3'b000, filtered_count}
                     + {3'b000, cycle_count};

    always_comb
    begin
        if (filtered_count == '0)
        begin
            filtered_next = ctts_pkg::FILTER_LOAD;
        end
        else
        begin
            filtered_next = blend_sum[18:3];
        end
    end

    assign diff   = filtered_next - level_offset;
    assign scaled = diff[15:4];

    always_comb
    begin
        if (filtered_next < level_offset)
        begin
            level_byte = 8'd0;
        end
        else if (scaled[11:8] != 4'd0)
        begin
            level_byte = 8'hFF;
        end
        else
        begin
            level_byte = scaled[7:0];
        end
    end

endmodule

`default_nettype wire

// ===== rtl/charge_transfer_touch_sensor_unit.sv =====
// Flow: a tick word is first held in the input stage; its result word is then
// loaded into the result register. Throughput: one tick word per cycle while the
// output side is not stalled. The next phase tick count, cycle count and filter value
// are all computed combinationally between the input stage and the result register.
// Reset: asynchronous, active low; restores the register defaults, starts in
// the charge phase with counters and filter cleared, and empties both stages.
// ----------------------------------------------------------------------------
// charge_transfer_touch_sensor_unit: charge-transfer capacitive touch sensor
// Sequences charge, transfer and discharge phases one tick word at a time,
// counts transfer cycles until the sense node reads high or the count times
// out, and reports a filtered, scaled touch level at the end of discharge.
// ----------------------------------------------------------------------------
`default_nettype none

module charge_transfer_touch_sensor_unit
(
    input  wire logic                             clk,
    input  wire logic                             rst_n,

    // Configuration write port
    input  wire logic                             cfg_write,
    input  wire logic [ctts_pkg::INDEX_W-1:0]     cfg_index,
    input  wire logic [ctts_pkg::REG_W-1:0]       cfg_data,

    // Tick word in
    input  wire logic                             in_valid,
    output logic                                  in_ready,
    input  wire logic                             sense_level,

    // Result word out
    output logic                                  out_valid,
    input  wire logic                             out_ready,
    output logic                                  sense_drive_enable,
    output logic                                  sense_drive_high,
    output logic                                  reference_ground_enable,
    output logic                                  level_valid,
    output logic      [7:0]                       level_byte
);

    typedef enum logic [1:0]
    {
        PH_CHARGE    = 2'd0,
        PH_TRANSFER  = 2'd1,
        PH_DISCHARGE = 2'd2
    } phase_t;

    // Configuration registers
    logic [ctts_pkg::REG_W-1:0] charge_ticks_reg;
    logic [ctts_pkg::REG_W-1:0] transfer_ticks_reg;
    logic [ctts_pkg::REG_W-1:0] discharge_ticks_reg;
    logic [ctts_pkg::REG_W-1:0] count_limit_reg;
    logic [ctts_pkg::REG_W-1:0] level_offset_reg;

    // Sensor state
    phase_t                     phase_reg,          phase_next;
    logic [ctts_pkg::REG_W-1:0] phase_ticks_reg,    phase_ticks_next;
    logic [ctts_pkg::REG_W-1:0] cycle_count_reg,    cycle_count_next;
    logic [ctts_pkg::REG_W-1:0] filtered_count_reg, filtered_count_next;

    // Input stage and result register
    logic                       stage_valid_reg;
    logic                       level_reg;
    logic                       out_valid_reg;
    ctts_pkg::ctts_result_t     result_reg, result_next;

    logic                       stage_fire;

    // Phase tick counter
    logic [ctts_pkg::REG_W-1:0] phase_len;
    logic [ctts_pkg::REG_W-1:0] ticks_inc;
    logic                       phase_done;

    // Filter outputs
    logic [ctts_pkg::REG_W-1:0] flt_value;
    logic [7:0]                 flt_byte;

    // ------------------------------------------------------------------
    // Handshake: advance the stage whenever the result register is free
    // or being emptied this cycle; take a new word whenever the stage
    // empties or is free.
    // ------------------------------------------------------------------
    assign stage_fire = stage_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready   = !stage_valid_reg || stage_fire;
    assign out_valid  = out_valid_reg;

    assign sense_drive_enable      = result_reg.sense_drive_enable;
    assign sense_drive_high        = result_reg.sense_drive_high;
    assign reference_ground_enable = result_reg.reference_ground_enable;
    assign level_valid             = result_reg.level_valid;
    assign level_byte              = result_reg.level_byte;

    // ------------------------------------------------------------------
    // Phase length select. An unused phase code runs as charge.
    // ------------------------------------------------------------------
    always_comb
    begin
        unique case (phase_reg)
            PH_TRANSFER:  phase_len = transfer_ticks_reg;
            PH_DISCHARGE: phase_len = discharge_ticks_reg;
            default:      phase_len = charge_ticks_reg;
        endcase
    end

    // The count wraps at 16 bits; a wrap, or reaching the length, ends the
    // phase. A length of zero therefore ends every phase after one tick, and
    // a length lowered mid phase ends it on the next tick.
    assign ticks_inc  = phase_ticks_reg + 16'd1;
    assign phase_done = (ticks_inc == '0) || (ticks_inc >= phase_len);

    ctts_filter u_filter
    (
        .filtered_count (filtered_count_reg),
        .cycle_count    (cycle_count_reg),
        .level_offset   (level_offset_reg),
        .filtered_next  (flt_value),
        .level_byte     (flt_byte)
    );

    // ------------------------------------------------------------------
    // One tick of the sequencer
    // ------------------------------------------------------------------
    always_comb
    begin
        phase_next          = phase_reg;
        phase_ticks_next    = phase_done ? '0 : ticks_inc;
        cycle_count_next    = cycle_count_reg;
        filtered_count_next = filtered_count_reg;
        result_next         = '0;

        unique case (phase_reg)
            PH_TRANSFER:
            begin
                // Release sense node, ground reference; sample at phase end
                result_next.reference_ground_enable = 1'b1;
                if (phase_done)
                begin
                    if (cycle_count_reg != ctts_pkg::COUNT_MAX)
                    begin
                        cycle_count_next = cycle_count_reg + 16'd1;
                    end
                    // Timeout test uses the count before the increment
                    if (level_reg || (cycle_count_reg >= count_limit_reg))
                    begin
                        phase_next = PH_DISCHARGE;
                    end
                    else
                    begin
                        phase_next = PH_CHARGE;
                    end
                end
            end
            PH_DISCHARGE:
            begin
                // Drive sense node low with reference grounded
                result_next.sense_drive_enable      = 1'b1;
                result_next.reference_ground_enable = 1'b1;
                if (phase_done)
                begin
                    result_next.level_valid = 1'b1;
                    result_next.level_byte  = flt_byte;
                    filtered_count_next     = flt_value;
                    cycle_count_next        = '0;
                    phase_next              = PH_CHARGE;
                end
            end
            default:
            begin
                // Charge: drive sense node high
                result_next.sense_drive_enable = 1'b1;
                result_next.sense_drive_high   = 1'b1;
                phase_next                     = phase_done ? PH_TRANSFER : PH_CHARGE;
            end
        endcase
    end

    // ------------------------------------------------------------------
    // Configuration registers; indexes past the map are dropped
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            charge_ticks_reg    <= ctts_pkg::RST_CHARGE_TICKS;
            transfer_ticks_reg  <= ctts_pkg::RST_TRANSFER_TICKS;
            discharge_ticks_reg <= ctts_pkg::RST_DISCHARGE_TICKS;
            count_limit_reg     <= ctts_pkg::RST_COUNT_LIMIT;
            level_offset_reg    <= ctts_pkg::RST_LEVEL_OFFSET;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                ctts_pkg::REG_CHARGE_TICKS:    charge_ticks_reg    <= cfg_data;
                ctts_pkg::REG_TRANSFER_TICKS:  transfer_ticks_reg  <= cfg_data;
                ctts_pkg::REG_DISCHARGE_TICKS: discharge_ticks_reg <= cfg_data;
                ctts_pkg::REG_COUNT_LIMIT:     count_limit_reg     <= cfg_data;
                ctts_pkg::REG_LEVEL_OFFSET:    level_offset_reg    <= cfg_data;
                default:                       ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Sequencer state, input stage and result register
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg          <= PH_CHARGE;
            phase_ticks_reg    <= '0;
            cycle_count_reg    <= '0;
            filtered_count_reg <= '0;
            stage_valid_reg    <= 1'b0;
            out_valid_reg      <= 1'b0;
        end
        else
        begin
            if (in_ready)
            begin
                stage_valid_reg <= in_valid;
            end

            if (stage_fire)
            begin
                phase_reg          <= phase_next;
                phase_ticks_reg    <= phase_ticks_next;
                cycle_count_reg    <= cycle_count_next;
                filtered_count_reg <= filtered_count_next;
                out_valid_reg      <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers: hold unless loaded
    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            level_reg <= sense_level;
        end
        if (stage_fire)
        begin
            result_reg <= result_next;
        end
    end

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------

    // A finished measurement always reports during a discharge drive
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && level_valid) |->
            (sense_drive_enable && !sense_drive_high && reference_ground_enable))
    else $error("level reported outside discharge drive");

    // No level byte without a finished measurement
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !level_valid) |-> (level_byte == 8'd0))
    else $error("level byte set without level_valid");

    // Discharge is only reached after at least one counted cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_DISCHARGE) |-> (cycle_count_reg != '0))
    else $error("discharge with empty cycle count");

    // End of discharge returns to charge and clears the count
    assert property (@(posedge clk) disable iff (!rst_n)
        (stage_fire && result_next.level_valid) |=>
            ((phase_reg == PH_CHARGE) && (cycle_count_reg == '0)))
    else $error("sequencer did not restart after a measurement");

endmodule

`default_nettype wire
